// ===== design/rc4_stream_cipher_macros.svh =====
// Assertion helpers shared by the cipher modules.
// Both expect clk_i and rst_ni in scope.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc4 assertion failed");

// Next-cycle implication.
`define RC4_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc4 assertion failed");

`endif

// ===== design/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  localparam int KeyDepth = 256;

  localparam logic [1:0] CmdKey   = 2'd0;
  localparam logic [1:0] CmdSched = 2'd1;
  localparam logic [1:0] CmdData  = 2'd2;

  localparam logic [8:0] KeyLenReset = 9'd16;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
    logic       message_start;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keyed;
  } rc4_out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_KEY_WR,
    OP_SCH_CLR,
    OP_INIT_WR,
    OP_SCH_RD,
    OP_SCH_J,
    OP_SCH_RDJ,
    OP_SCH_WRK,
    OP_SCH_WRJ,
    OP_SCH_DONE,
    OP_RST_CLR,
    OP_CP_RD,
    OP_CP_WR,
    OP_KS_INC,
    OP_KS_RDI,
    OP_KS_LATI,
    OP_KS_RDJ,
    OP_KS_WRI,
    OP_KS_WRJ,
    OP_KS_RDT,
    OP_KS_EMIT,
    OP_PLAIN_EMIT
  } rc4_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_LOOP,
    J_END,
    J_EMIT,
    J_DISPATCH
  } rc4_jmp_e;

  typedef logic [4:0] rc4_pc_t;

  localparam rc4_pc_t PcIdle  = 5'd0;
  localparam rc4_pc_t PcKey   = 5'd1;
  localparam rc4_pc_t PcSch   = 5'd2;
  localparam rc4_pc_t PcInit  = 5'd3;
  localparam rc4_pc_t PcSchLp = 5'd4;
  localparam rc4_pc_t PcRst   = 5'd10;
  localparam rc4_pc_t PcCpLp  = 5'd11;
  localparam rc4_pc_t PcCpWr  = 5'd12;
  localparam rc4_pc_t PcKs    = 5'd13;
  localparam rc4_pc_t PcPlain = 5'd21;

  typedef struct packed {
    rc4_op_e  op;
    rc4_jmp_e jmp;
    rc4_pc_t  target;
  } rc4_uword_t;

  typedef struct packed {
    rc4_op_e op;
    logic    accept;
  } rc4_ctrl_t;

  typedef struct packed {
    logic k_last;
    logic keyed;
    logic out_free;
  } rc4_stat_t;

  // Microcode ROM: one control word per step.
  function automatic rc4_uword_t rc4_ucode(rc4_pc_t pc);
    rc4_uword_t w;
    w = '{op: OP_NOP, jmp: J_END, target: PcIdle};
    unique case (pc)
      5'd0:  w = '{op: OP_NOP,        jmp: J_DISPATCH, target: PcIdle};
      5'd1:  w = '{op: OP_KEY_WR,     jmp: J_END,      target: PcIdle};
      5'd2:  w = '{op: OP_SCH_CLR,    jmp: J_NEXT,     target: PcIdle};
      5'd3:  w = '{op: OP_INIT_WR,    jmp: J_LOOP,     target: PcInit};
      5'd4:  w = '{op: OP_SCH_RD,     jmp: J_NEXT,     target: PcIdle};
      5'd5:  w = '{op: OP_SCH_J,      jmp: J_NEXT,     target: PcIdle};
      5'd6:  w = '{op: OP_SCH_RDJ,    jmp: J_NEXT,     target: PcIdle};
      5'd7:  w = '{op: OP_SCH_WRK,    jmp: J_NEXT,     target: PcIdle};
      5'd8:  w = '{op: OP_SCH_WRJ,    jmp: J_LOOP,     target: PcSchLp};
      5'd9:  w = '{op: OP_SCH_DONE,   jmp: J_END,      target: PcIdle};
      5'd10: w = '{op: OP_RST_CLR,    jmp: J_NEXT,     target: PcIdle};
      5'd11: w = '{op: OP_CP_RD,      jmp: J_NEXT,     target: PcIdle};
      5'd12: w = '{op: OP_CP_WR,      jmp: J_LOOP,     target: PcCpLp};
      5'd13: w = '{op: OP_KS_INC,     jmp: J_NEXT,     target: PcIdle};
      5'd14: w = '{op: OP_KS_RDI,     jmp: J_NEXT,     target: PcIdle};
      5'd15: w = '{op: OP_KS_LATI,    jmp: J_NEXT,     target: PcIdle};
      5'd16: w = '{op: OP_KS_RDJ,     jmp: J_NEXT,     target: PcIdle};
      5'd17: w = '{op: OP_KS_WRI,     jmp: J_NEXT,     target: PcIdle};
      5'd18: w = '{op: OP_KS_WRJ,     jmp: J_NEXT,     target: PcIdle};
      5'd19: w = '{op: OP_KS_RDT,     jmp: J_NEXT,     target: PcIdle};
      5'd20: w = '{op: OP_KS_EMIT,    jmp: J_EMIT,     target: PcIdle};
      5'd21: w = '{op: OP_PLAIN_EMIT, jmp: J_EMIT,     target: PcIdle};
      default: w = '{op: OP_NOP, jmp: J_END, target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/rc4_seq.sv =====
`default_nettype none

module rc4_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  input  logic              in_start_i,
  output logic              in_ready_o,
  input  rc4_pkg::rc4_stat_t stat_i,
  output rc4_pkg::rc4_ctrl_t ctrl_o
);
  import rc4_pkg::*;

  rc4_pc_t    pc_q, pc_d;
  rc4_uword_t uw;
  logic       accept;

  assign uw         = rc4_ucode(pc_q);
  assign in_ready_o = (uw.jmp == J_DISPATCH);
  assign accept     = in_valid_i & in_ready_o;
  assign ctrl_o     = '{op: uw.op, accept: accept};

  always_comb begin
    pc_d = pc_q;
    unique case (uw.jmp)
      J_NEXT: pc_d = pc_q + 5'd1;
      J_LOOP: pc_d = stat_i.k_last ? pc_q + 5'd1 : uw.target;
      J_END:  pc_d = PcIdle;
      J_EMIT: pc_d = stat_i.out_free ? PcIdle : pc_q;
      J_DISPATCH: begin
        if (accept) begin
          case (in_cmd_i)
            CmdKey:   pc_d = PcKey;
            CmdSched: pc_d = PcSch;
            CmdData: begin
              if (!stat_i.keyed) begin
                pc_d = PcPlain;
              end else if (in_start_i) begin
                pc_d = PcRst;
              end else begin
                pc_d = PcKs;
              end
            end
            default:  pc_d = PcIdle;
          endcase
        end
      end
      default: pc_d = PcIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

`include "rc4_stream_cipher_macros.svh"

  `RC4_ASSERT_NXT(a_restart_entry,
    accept && in_cmd_i == CmdData && in_start_i && stat_i.keyed, pc_q == PcRst)
  `RC4_ASSERT_NXT(a_copy_to_keystream, pc_q == PcCpWr && stat_i.k_last, pc_q == PcKs)
  `RC4_ASSERT_NXT(a_unkeyed_bypass,
    accept && in_cmd_i == CmdData && !stat_i.keyed, pc_q == PcPlain)

endmodule

`default_nettype wire

// ===== design/rc4_dp.sv =====
`default_nettype none

module rc4_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rc4_pkg::rc4_ctrl_t ctrl_i,
  input  rc4_pkg::rc4_in_t   in_data_i,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rc4_pkg::rc4_out_t  out_data_o,
  output rc4_pkg::rc4_stat_t stat_o
);
  import rc4_pkg::*;

  logic [7:0] key_mem  [KeyDepth];
  logic [7:0] base_mem [256];
  logic [7:0] work_mem [256];

  rc4_in_t    item_q;
  rc4_out_t   out_q;
  logic       out_valid_q, out_valid_d;
  logic       keyed_q, keyed_d;
  logic [8:0] key_len_q;
  logic [7:0] k_q, k_d, i_q, i_d, j_q, j_d, si_q, si_d, sj_q, sj_d;
  logic [8:0] kp_q, kp_d, kp_inc, eff_len;
  logic       out_free, emit;

  logic [7:0] key_rd_q, base_rd_q, work_rd_q;
  logic [7:0] key_raddr, base_raddr, work_raddr;
  logic       key_we, base_we, work_we;
  logic [7:0] key_waddr, base_waddr, work_waddr;
  logic [7:0] key_wdata, base_wdata, work_wdata;

  assign out_free = !out_valid_q | out_ready_i;
  assign emit     = (ctrl_i.op == OP_KS_EMIT || ctrl_i.op == OP_PLAIN_EMIT) && out_free;

  // Zero counts as one, anything above the store depth as the full store.
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == 9'd0) begin
      eff_len = 9'd1;
    end else if (key_len_q > 9'(KeyDepth)) begin
      eff_len = 9'(KeyDepth);
    end
  end
  assign kp_inc = kp_q + 9'd1;

  assign stat_o = '{k_last: (k_q == 8'hFF), keyed: keyed_q, out_free: out_free};

  // Memory addressing
  always_comb begin
    key_raddr  = kp_q[7:0];
    base_raddr = (ctrl_i.op == OP_SCH_RDJ) ? j_q : k_q;
    unique case (ctrl_i.op)
      OP_KS_RDJ:              work_raddr = j_q;
      OP_KS_RDT, OP_KS_EMIT:  work_raddr = 8'(si_q + sj_q);
      default:                work_raddr = i_q;
    endcase

    key_we    = (ctrl_i.op == OP_KEY_WR) && ({1'b0, item_q.key_index} < 9'(KeyDepth));
    key_waddr = item_q.key_index;
    key_wdata = item_q.key_byte;

    base_we    = 1'b0;
    base_waddr = k_q;
    base_wdata = k_q;
    work_we    = 1'b0;
    work_waddr = k_q;
    work_wdata = k_q;
    unique case (ctrl_i.op)
      OP_INIT_WR: begin
        base_we = 1'b1;
        work_we = 1'b1;
      end
      OP_SCH_WRK: begin
        base_we    = 1'b1;
        base_wdata = base_rd_q;
        work_we    = 1'b1;
        work_wdata = base_rd_q;
      end
      OP_SCH_WRJ: begin
        base_we    = 1'b1;
        base_waddr = j_q;
        base_wdata = si_q;
        work_we    = 1'b1;
        work_waddr = j_q;
        work_wdata = si_q;
      end
      OP_CP_WR: begin
        work_we    = 1'b1;
        work_wdata = base_rd_q;
      end
      OP_KS_WRI: begin
        work_we    = 1'b1;
        work_waddr = i_q;
        work_wdata = work_rd_q;
      end
      OP_KS_WRJ: begin
        work_we    = 1'b1;
        work_waddr = j_q;
        work_wdata = si_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_waddr] <= base_wdata;
    end
    base_rd_q <= base_mem[base_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_q <= work_mem[work_raddr];
  end

  // Datapath register updates
  always_comb begin
    k_d     = k_q;
    kp_d    = kp_q;
    i_d     = i_q;
    j_d     = j_q;
    si_d    = si_q;
    sj_d    = sj_q;
    keyed_d = keyed_q;
    unique case (ctrl_i.op)
      OP_SCH_CLR: begin
        k_d  = 8'd0;
        kp_d = 9'd0;
        j_d  = 8'd0;
      end
      OP_INIT_WR, OP_CP_WR: k_d = k_q + 8'd1;
      OP_SCH_J: begin
        j_d  = 8'(j_q + base_rd_q + key_rd_q);
        si_d = base_rd_q;
      end
      OP_SCH_WRJ: begin
        k_d  = k_q + 8'd1;
        kp_d = (kp_inc >= eff_len) ? 9'd0 : kp_inc;
      end
      OP_SCH_DONE: begin
        keyed_d = 1'b1;
        i_d     = 8'd0;
        j_d     = 8'd0;
      end
      OP_RST_CLR: begin
        k_d = 8'd0;
        i_d = 8'd0;
        j_d = 8'd0;
      end
      OP_KS_INC: i_d = i_q + 8'd1;
      OP_KS_LATI: begin
        si_d = work_rd_q;
        j_d  = 8'(j_q + work_rd_q);
      end
      OP_KS_WRI: sj_d = work_rd_q;
      default: ;
    endcase

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      kp_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      key_len_q   <= KeyLenReset;
    end else begin
      k_q         <= k_d;
      kp_q        <= kp_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    sj_q <= sj_d;
    if (ctrl_i.accept) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      if (ctrl_i.op == OP_KS_EMIT) begin
        out_q <= '{out_byte: work_rd_q ^ item_q.data_byte, keyed: 1'b1};
      end else begin
        out_q <= '{out_byte: item_q.data_byte, keyed: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "rc4_stream_cipher_macros.svh"

  `RC4_ASSERT_NXT(a_sched_sets_keyed, ctrl_i.op == OP_SCH_DONE, keyed_q)
  `RC4_ASSERT_IMP(a_key_ptr_in_range, 1'b1, kp_q < eff_len || ctrl_i.op != OP_SCH_RD)

endmodule

`default_nettype wire

// ===== design/rc4_stream_cipher.sv =====
// RC4 byte cipher with a microcoded control sequencer.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one command per
// transaction: write a key byte, run the key schedule, or process a data byte.
// Output channel (out_valid_o/out_ready_i, out_data_o) carries one result per
// data transaction; key writes and schedules give none.
// cfg_we_i/cfg_data_i write key_length; write it only while the block is idle.
// One item is worked on at a time, sequenced from the microcode ROM over
// permutation memories with a read port and a separate write port:
//   key write           writes the addressed key byte
//   key schedule        clear, 256 fill steps, 5 steps per swap, keyed set at the end
//   data byte           step i and j, swap, read the keystream byte; result registered at emit
//   data with restart   two-step copy of 256 entries first, then as a data byte
//   data before keying  byte passed through with keyed low
// Reset clears the indices, the keyed flag and the output valid flag and sets
// key_length to 16; the key store and permutations hold nothing until written.
// The result sits in an output register, so the next item is taken while it
// waits; a data item reaching its final step while the register is still full
// holds there until the receiver takes the pending result.
`default_nettype none

module rc4_stream_cipher (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rc4_pkg::rc4_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rc4_pkg::rc4_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [8:0]       cfg_data_i
);
  import rc4_pkg::*;

  rc4_ctrl_t ctrl;
  rc4_stat_t stat;

  rc4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .in_start_i (in_data_i.message_start),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rc4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import rc4_pkg::*;

  // the block ignores the unused command code
  localparam logic [1:0] CmdNone = 2'd3;
  localparam int unsigned CycleLimit = 1_000_000;
  // longer than a full key schedule, which gives no result
  localparam int SettleCycles = 2000;
  localparam int LongHold = 600;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  rc4_in_t   in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  rc4_out_t  out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  rc4_stream_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cipher state as the block should hold it
  logic [7:0] key_mem  [256];
  logic [7:0] base_perm[256];
  logic [7:0] work_perm[256];
  logic [7:0] idx_i = '0;
  logic [7:0] idx_j = '0;
  logic       keyed_state = 1'b0;
  logic [8:0] key_len = KeyLenReset;

  rc4_in_t  cmd_q[$];
  rc4_out_t cipher_results[$];
  logic [255:0] key_set = '0;

  int unsigned cycle_count = 0;
  int unsigned offered_items = 0;
  int unsigned accepted_items = 0;
  int unsigned results_checked = 0;
  int unsigned fault_count = 0;
  int unsigned sched_count = 0;
  int unsigned restart_count = 0;
  int unsigned items_built = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;

  task automatic advance_cipher(input rc4_in_t it);
    int n;
    int k;
    logic [7:0] j8;
    logic [7:0] t;
    rc4_out_t res;
    case (it.command)
      CmdKey: key_mem[it.key_index] = it.key_byte;
      CmdSched: begin
        n = (key_len == 0) ? 1 : ((key_len > KeyDepth) ? KeyDepth : int'(key_len));
        for (k = 0; k < 256; k++) base_perm[k] = k[7:0];
        j8 = '0;
        for (k = 0; k < 256; k++) begin
          j8 = j8 + base_perm[k] + key_mem[k % n];
          t = base_perm[k];
          base_perm[k] = base_perm[j8];
          base_perm[j8] = t;
        end
        work_perm = base_perm;
        idx_i = '0;
        idx_j = '0;
        keyed_state = 1'b1;
        sched_count++;
      end
      CmdData: begin
        if (!keyed_state) begin
          res.out_byte = it.data_byte;
          res.keyed = 1'b0;
        end else begin
          if (it.message_start) begin
            work_perm = base_perm;
            idx_i = '0;
            idx_j = '0;
            restart_count++;
          end
          idx_i = idx_i + 8'd1;
          idx_j = idx_j + work_perm[idx_i];
          t = work_perm[idx_i];
          work_perm[idx_i] = work_perm[idx_j];
          work_perm[idx_j] = t;
          t = work_perm[idx_i] + work_perm[idx_j];
          res.out_byte = it.data_byte ^ work_perm[t];
          res.keyed = 1'b1;
        end
        cipher_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_fault(input string why, input rc4_out_t want, input rc4_out_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected out_byte %02h keyed %0b, got out_byte %02h keyed %0b",
               why, want.out_byte, want.keyed, got.out_byte, got.keyed);
  endtask

  // sample the outputs and record transactions at the rising edge
  always @(posedge clk_i) begin : watch_blk
    rc4_out_t want;
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (cipher_results.size() == 0) begin
          report_fault("unexpected result", '0, out_data_o);
        end else begin
          want = cipher_results.pop_front();
          if (want.out_byte !== out_data_o.out_byte || want.keyed !== out_data_o.keyed)
            report_fault("result mismatch", want, out_data_o);
          results_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        accepted_items++;
        advance_cipher(in_data_i);
      end
    end
  end

  always @(negedge clk_i) begin : drive_blk
    logic    nv;
    rc4_in_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (in_valid_i && accepted_items < offered_items) begin
      // hold until the transaction is taken
    end else if (gap_left > 0) begin
      gap_left--;
      nv = 1'b0;
    end else if (cmd_q.size() == 0) begin
      nv = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 4);
      nv = 1'b0;
    end else begin
      nd = cmd_q.pop_front();
      nv = 1'b1;
      offered_items++;
    end
    in_valid_i <= nv;
    in_data_i <= nd;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && !calm && results_checked >= 150) begin
      // long hold-off so the block backs up and stalls its input
      long_hold_done = 1'b1;
      hold_left = LongHold - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] kidx,
                           input logic [7:0] kbyte, input logic [7:0] dbyte,
                           input logic start);
    rc4_in_t it;
    it.command = cmd;
    it.key_index = kidx;
    it.key_byte = kbyte;
    it.data_byte = dbyte;
    it.message_start = start;
    if (cmd == CmdKey) key_set[kidx] = 1'b1;
    cmd_q.push_back(it);
    items_built++;
  endtask

  task automatic push_data(input logic start);
    push_item(CmdData, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), start);
  endtask

  task automatic push_schedule();
    push_item(CmdSched, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // key bytes for the schedule must all be written before it runs
  task automatic build_phase(input logic [8:0] klen, input int n_items);
    int eff;
    int k;
    int r;
    int burst;
    int unsigned first;
    first = items_built;
    eff = (klen == 0) ? 1 : ((klen > KeyDepth) ? KeyDepth : int'(klen));
    for (k = 0; k < eff; k++)
      if (!key_set[k])
        push_item(CmdKey, k[7:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    push_schedule();
    while (items_built - first < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_schedule();
      end else if (r < 6) begin
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst; k++)
          push_item(CmdKey, 8'($urandom_range(0, eff - 1)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        push_schedule();
      end else if (r < 12) begin
        push_item(CmdKey, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 15) begin
        push_item(CmdNone, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 28) begin
        push_data(1'b1);
        burst = $urandom_range(1, 15);
        for (k = 0; k < burst; k++) push_data(1'b0);
      end else begin
        push_data($urandom_range(0, 19) == 0);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || cipher_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_key_len(input logic [8:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    key_len = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pass-through before keying, start flag has no effect yet
    push_item(CmdData, 8'hFF, 8'hFF, 8'h00, 1'b0);
    push_item(CmdData, 8'h00, 8'h00, 8'hFF, 1'b1);
    push_item(CmdNone, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    for (k = 0; k < 16; k++)
      push_item(CmdKey, k[7:0], (k == 0) ? 8'h00 : ((k == 1) ? 8'hFF : 8'($urandom)),
                8'($urandom), k[0]);
    push_item(CmdSched, 8'h00, 8'h00, 8'h00, 1'b1);
    push_item(CmdData, 8'h00, 8'h00, 8'hFF, 1'b0);
    push_item(CmdData, 8'h00, 8'h00, 8'h00, 1'b1);
    push_item(CmdData, 8'hFF, 8'hFF, 8'h5A, 1'b0);
    // a key write after the schedule only counts at the next one
    push_item(CmdKey, 8'h03, 8'h77, 8'h00, 1'b0);
    push_item(CmdData, 8'h00, 8'h00, 8'h33, 1'b0);
    push_item(CmdNone, 8'h00, 8'h00, 8'h00, 1'b0);
    push_item(CmdSched, 8'h00, 8'h00, 8'h00, 1'b0);
    push_item(CmdData, 8'h00, 8'h00, 8'hC3, 1'b1);
    wait_idle();

    write_key_len(9'd1);
    build_phase(9'd1, 100);
    wait_idle();
    write_key_len(9'd256);
    build_phase(9'd256, 330);
    wait_idle();
    write_key_len(9'd0);
    build_phase(9'd0, 80);
    wait_idle();
    write_key_len(9'd511);
    build_phase(9'd511, 80);
    wait_idle();
    write_key_len(9'd257);
    build_phase(9'd257, 60);
    wait_idle();
    write_key_len(9'd2);
    build_phase(9'd2, 80);
    wait_idle();
    write_key_len(9'($urandom_range(3, 255)));
    build_phase(key_len, 80);
    wait_idle();

    // final stretch without idling on either side
    calm = 1'b1;
    write_key_len(KeyLenReset);
    build_phase(KeyLenReset, 100);
    wait_idle();

    $display("summary: %0d transactions in, %0d results checked, %0d key schedules, %0d restarts",
             accepted_items, results_checked, sched_count, restart_count);
    $display("summary: key lengths 0, 1, 2, 16, 256, 257, 511 and one random, plain bytes");
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
